[rtl/core/bbw_pkg.sv]
// Shared constants, register indexes and sequencer states for the Bollinger band window.
package bbw_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int LEN_W      = 7;
    localparam int FACTOR_W   = 16;
    localparam int FRAC_W     = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    // population stddev of 24-bit samples stays below 2^23, variance below 2^46
    localparam int SD_W       = SAMPLE_W - 1;
    localparam int VAR_W      = 2 * SD_W;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = '1;
    localparam logic [LEN_W-1:0]    LEN_RESET    = 7'd20;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_BAND_FACTOR   = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQ_WAIT,
        ST_MOM,
        ST_MOM_WAIT,
        ST_VDIV,
        ST_VDIV_WAIT,
        ST_ROOT,
        ST_SCALE,
        ST_SCALE_WAIT,
        ST_OUT
    } state_t;

endpackage

[rtl/core/bbw_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle.
module bbw_mul #(
    parameter int A_W = 24,
    parameter int B_W = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 busy,
    output logic [A_W+B_W-1:0]   prod
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     a_reg;
    logic [A_W+B_W-1:0] p_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [A_W:0]       add_sum;

    // low half holds the multiplier bits still to consume
    assign add_sum = {1'b0, p_reg[A_W+B_W-1:B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(B_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            p_reg <= {{A_W{1'b0}}, b};
        end else if (busy_reg) begin
            p_reg <= {add_sum, p_reg[B_W-1:1]};
        end
    end

    assign busy = busy_reg;
    assign prod = p_reg;

endmodule

[rtl/core/bbw_div.sv]
// Restoring divider, one quotient bit per cycle; quotient must fit in Q_W bits.
module bbw_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 7,
    parameter int Q_W   = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [Q_W-1:0]   quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] part_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   sh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {part_reg, sh_reg[Q_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(Q_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // dividend bits leave the top of sh_reg as quotient bits enter at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            part_reg <= DEN_W'(num >> Q_W);
            sh_reg   <= num[Q_W-1:0];
            den_reg  <= den;
        end else if (busy_reg) begin
            part_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            sh_reg   <= {sh_reg[Q_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = sh_reg;

endmodule

[rtl/core/bollinger_band_window.sv]
// Top level of the Bollinger band window: ring window, running moments and band sequencer.
//
// Usage:
//   s_valid/s_ready/s_sample take one 24-bit price word. Each word enters a
//   ring window of the last N words (N = window_length, 0 means 1, capped at
//   MAX_WINDOW) and yields one result word on m_*: lower, middle and upper
//   band, population stddev and a window-full flag.
//   cfg_wr_en/cfg_index/cfg_wdata write register 0 (window_length, clears the
//   window and all running sums) or register 1 (band_factor, Q4.12). Write
//   only while idle. Other indexes are ignored.
//   The sequencer runs squaring, then sum-of-squares times N, sum squared
//   and the mean divide in parallel, then the variance divide, the square
//   root at two bits per cycle and the factor multiply. One word is in
//   flight at a time: a new word is accepted only once the last result
//   has been loaded into the output register.
//   The result sits in an output register; once loaded, s_ready returns and a
//   new word is worked on while the receiver stalls. If the output register
//   is still full when the next result is done, the sequencer holds there.
//   Reset: synchronous, active low; window cleared through per-slot valid
//   bits, window_length = 20, band_factor = 8192. No clearing pass.
module bollinger_band_window #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [bbw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbw_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bbw_pkg::SAMPLE_W-1:0]    s_sample,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bbw_pkg::SAMPLE_W-1:0]    m_lower_band,
    output logic [bbw_pkg::SAMPLE_W-1:0]    m_middle_band,
    output logic [bbw_pkg::SAMPLE_W-1:0]    m_upper_band,
    output logic [bbw_pkg::SAMPLE_W-1:0]    m_std_dev,
    output logic                            m_window_full
);

    localparam int SAMPLE_W = bbw_pkg::SAMPLE_W;
    localparam int LEN_MAX  = (1 << bbw_pkg::LEN_W) - 1;
    // largest N actually reachable
    localparam int NMAX     = (MAX_WINDOW < LEN_MAX) ? MAX_WINDOW : LEN_MAX;
    localparam int NW       = $clog2(NMAX + 1);
    localparam int AW       = $clog2(MAX_WINDOW);
    localparam int CW       = ((AW > NW) ? AW : NW) + 1;
    localparam int SUM_W    = SAMPLE_W + $clog2(NMAX);
    localparam int SQ_W     = 2 * SAMPLE_W + $clog2(NMAX);
    localparam int NSQ_W    = SQ_W + NW;
    localparam int SSQ_W    = 2 * SUM_W;
    localparam int NUM_W    = (NSQ_W > SSQ_W) ? NSQ_W : SSQ_W;
    localparam int DEN_W    = 2 * NW;
    localparam int SD_W     = bbw_pkg::SD_W;
    localparam int VAR_W    = bbw_pkg::VAR_W;
    localparam int FAC_W    = bbw_pkg::FACTOR_W;
    localparam int MF_W     = SD_W + FAC_W;
    localparam int OFF_W    = MF_W - bbw_pkg::FRAC_W;
    localparam int RC_W     = $clog2(SD_W + 1);

    // configuration
    logic [bbw_pkg::LEN_W-1:0] wl_reg;
    logic [FAC_W-1:0]          factor_reg;
    logic [NW-1:0]             eff_n;
    logic                      cfg_clear;

    // window state
    logic [SAMPLE_W-1:0]   ring_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] ring_vld_reg;
    logic [AW-1:0]         pos_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SQ_W-1:0]       sumsq_reg;
    logic [NW-1:0]         fill_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SAMPLE_W-1:0]   rdata_reg;
    logic                  rvld_reg;
    logic [SAMPLE_W-1:0]   old_sample;
    logic [CW-1:0]         pos_inc;

    // sequencer
    bbw_pkg::state_t state_reg, state_next;
    logic sq_start, mom_start, vdiv_start, scale_start, out_load, sumsq_load, root_init;
    logic s_fire;

    // arithmetic units
    logic                  sq_s_busy, sq_o_busy, nsq_busy, ssq_busy, mdiv_busy, vdiv_busy;
    logic                  scale_busy;
    logic [2*SAMPLE_W-1:0] sq_s_prod, sq_o_prod;
    logic [NSQ_W-1:0]      nsq_prod;
    logic [SSQ_W-1:0]      ssq_prod;
    logic [SAMPLE_W-1:0]   mean_quot;
    logic [VAR_W-1:0]      var_quot;
    logic [MF_W-1:0]       scale_prod;
    logic [NUM_W-1:0]      nsq_ext, ssq_ext, var_num;
    logic [DEN_W-1:0]      n_squared;

    // square root
    logic [VAR_W-1:0]  v_sh_reg;
    logic [SD_W+1:0]   rem_reg;
    logic [SD_W-1:0]   root_reg;
    logic [RC_W-1:0]   root_cnt_reg;
    logic [SD_W+1:0]   rem_shift;
    logic [SD_W+1:0]   root_trial;
    logic              root_ge;

    // bands
    logic [OFF_W-1:0]  offset;
    logic [OFF_W-1:0]  mean_ext;
    logic [OFF_W:0]    upper_sum;
    logic [SAMPLE_W-1:0] lower_val, upper_val;

    // output register
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_lower_reg, m_middle_reg, m_upper_reg, m_sd_reg;
    logic                m_full_reg;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    assign cfg_clear = cfg_wr_en && (cfg_index == bbw_pkg::REG_WINDOW_LENGTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg     <= bbw_pkg::LEN_RESET;
            factor_reg <= bbw_pkg::FACTOR_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == bbw_pkg::REG_WINDOW_LENGTH) begin
                wl_reg <= cfg_wdata[bbw_pkg::LEN_W-1:0];
            end
            if (cfg_index == bbw_pkg::REG_BAND_FACTOR) begin
                factor_reg <= cfg_wdata[FAC_W-1:0];
            end
        end
    end

    // zero length acts as one, long windows cap at the ring depth
    always_comb begin
        if (wl_reg == '0) begin
            eff_n = NW'(1);
        end else if (32'(wl_reg) > 32'(MAX_WINDOW)) begin
            eff_n = NW'(MAX_WINDOW);
        end else begin
            eff_n = NW'(wl_reg);
        end
    end

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    assign s_ready = (state_reg == bbw_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        sq_start    = 1'b0;
        sumsq_load  = 1'b0;
        mom_start   = 1'b0;
        vdiv_start  = 1'b0;
        root_init   = 1'b0;
        scale_start = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            bbw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bbw_pkg::ST_SQ;
                end
            end
            bbw_pkg::ST_SQ: begin
                sq_start   = 1'b1;
                state_next = bbw_pkg::ST_SQ_WAIT;
            end
            bbw_pkg::ST_SQ_WAIT: begin
                if (!sq_s_busy && !sq_o_busy) begin
                    sumsq_load = 1'b1;
                    state_next = bbw_pkg::ST_MOM;
                end
            end
            bbw_pkg::ST_MOM: begin
                mom_start  = 1'b1;
                state_next = bbw_pkg::ST_MOM_WAIT;
            end
            bbw_pkg::ST_MOM_WAIT: begin
                if (!nsq_busy && !ssq_busy && !mdiv_busy) begin
                    state_next = bbw_pkg::ST_VDIV;
                end
            end
            bbw_pkg::ST_VDIV: begin
                vdiv_start = 1'b1;
                state_next = bbw_pkg::ST_VDIV_WAIT;
            end
            bbw_pkg::ST_VDIV_WAIT: begin
                if (!vdiv_busy) begin
                    root_init  = 1'b1;
                    state_next = bbw_pkg::ST_ROOT;
                end
            end
            bbw_pkg::ST_ROOT: begin
                if (root_cnt_reg == RC_W'(1)) begin
                    state_next = bbw_pkg::ST_SCALE;
                end
            end
            bbw_pkg::ST_SCALE: begin
                scale_start = 1'b1;
                state_next  = bbw_pkg::ST_SCALE_WAIT;
            end
            bbw_pkg::ST_SCALE_WAIT: begin
                if (!scale_busy) begin
                    state_next = bbw_pkg::ST_OUT;
                end
            end
            bbw_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = bbw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bbw_pkg::ST_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Ring window and running moments
    //------------------------------------------------------------------
    // unwritten slots read as zero through their valid bit
    assign old_sample = rvld_reg ? rdata_reg : '0;
    assign pos_inc    = CW'(pos_reg) + CW'(1);

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg <= s_sample;
            rdata_reg  <= ring_mem[pos_reg];
            rvld_reg   <= ring_vld_reg[pos_reg];
        end
        if (state_reg == bbw_pkg::ST_SQ) begin
            ring_mem[pos_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            fill_reg     <= '0;
        end else if (cfg_clear) begin
            ring_vld_reg <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            fill_reg     <= '0;
        end else begin
            if (state_reg == bbw_pkg::ST_SQ) begin
                ring_vld_reg[pos_reg] <= 1'b1;
                // true result stays in range, so modular wrap is harmless
                sum_reg <= sum_reg + SUM_W'(sample_reg) - SUM_W'(old_sample);
                if (pos_inc >= CW'(eff_n)) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_inc[AW-1:0];
                end
                if (fill_reg < eff_n) begin
                    fill_reg <= fill_reg + NW'(1);
                end
            end
            if (sumsq_load) begin
                sumsq_reg <= sumsq_reg + SQ_W'(sq_s_prod) - SQ_W'(sq_o_prod);
            end
        end
    end

    //------------------------------------------------------------------
    // Serial arithmetic
    //------------------------------------------------------------------
    bbw_mul #(.A_W(SAMPLE_W), .B_W(SAMPLE_W)) u_sq_new (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .a(sample_reg), .b(sample_reg), .busy(sq_s_busy), .prod(sq_s_prod)
    );

    bbw_mul #(.A_W(SAMPLE_W), .B_W(SAMPLE_W)) u_sq_old (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .a(old_sample), .b(old_sample), .busy(sq_o_busy), .prod(sq_o_prod)
    );

    bbw_mul #(.A_W(SQ_W), .B_W(NW)) u_nsq (
        .aclk(aclk), .aresetn(aresetn), .start(mom_start),
        .a(sumsq_reg), .b(eff_n), .busy(nsq_busy), .prod(nsq_prod)
    );

    bbw_mul #(.A_W(SUM_W), .B_W(SUM_W)) u_ssq (
        .aclk(aclk), .aresetn(aresetn), .start(mom_start),
        .a(sum_reg), .b(sum_reg), .busy(ssq_busy), .prod(ssq_prod)
    );

    // mean of 24-bit samples fits in 24 quotient bits
    bbw_div #(.NUM_W(SUM_W), .DEN_W(NW), .Q_W(SAMPLE_W)) u_mean_div (
        .aclk(aclk), .aresetn(aresetn), .start(mom_start),
        .num(sum_reg), .den(eff_n), .busy(mdiv_busy), .quot(mean_quot)
    );

    assign nsq_ext   = NUM_W'(nsq_prod);
    assign ssq_ext   = NUM_W'(ssq_prod);
    assign var_num   = (nsq_ext > ssq_ext) ? (nsq_ext - ssq_ext) : '0;
    assign n_squared = DEN_W'(eff_n) * DEN_W'(eff_n);

    bbw_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(VAR_W)) u_var_div (
        .aclk(aclk), .aresetn(aresetn), .start(vdiv_start),
        .num(var_num), .den(n_squared), .busy(vdiv_busy), .quot(var_quot)
    );

    // integer square root, two radicand bits per cycle
    assign rem_shift  = {rem_reg[SD_W-1:0], v_sh_reg[VAR_W-1:VAR_W-2]};
    assign root_trial = {root_reg, 2'b01};
    assign root_ge    = (rem_shift >= root_trial);

    always_ff @(posedge aclk) begin
        if (root_init) begin
            v_sh_reg     <= var_quot;
            rem_reg      <= '0;
            root_reg     <= '0;
            root_cnt_reg <= RC_W'(SD_W);
        end else if (state_reg == bbw_pkg::ST_ROOT) begin
            v_sh_reg     <= {v_sh_reg[VAR_W-3:0], 2'b00};
            rem_reg      <= root_ge ? (rem_shift - root_trial) : rem_shift;
            root_reg     <= {root_reg[SD_W-2:0], root_ge};
            root_cnt_reg <= root_cnt_reg - RC_W'(1);
        end
    end

    bbw_mul #(.A_W(SD_W), .B_W(FAC_W)) u_scale (
        .aclk(aclk), .aresetn(aresetn), .start(scale_start),
        .a(root_reg), .b(factor_reg), .busy(scale_busy), .prod(scale_prod)
    );

    //------------------------------------------------------------------
    // Bands and output register
    //------------------------------------------------------------------
    assign offset    = scale_prod[MF_W-1:bbw_pkg::FRAC_W];
    assign mean_ext  = OFF_W'(mean_quot);
    assign lower_val = (mean_ext > offset) ? SAMPLE_W'(mean_ext - offset) : '0;
    assign upper_sum = {1'b0, offset} + (OFF_W+1)'(mean_quot);
    assign upper_val = (upper_sum > (OFF_W+1)'(bbw_pkg::SAMPLE_MAX)) ?
                       bbw_pkg::SAMPLE_MAX : SAMPLE_W'(upper_sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_lower_reg  <= lower_val;
            m_middle_reg <= mean_quot;
            m_upper_reg  <= upper_val;
            m_sd_reg     <= SAMPLE_W'(root_reg);
            m_full_reg   <= (fill_reg >= eff_n);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_lower_band  = m_lower_reg;
    assign m_middle_band = m_middle_reg;
    assign m_upper_band  = m_upper_reg;
    assign m_std_dev     = m_sd_reg;
    assign m_window_full = m_full_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("second word accepted while one is in flight");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= eff_n)
        else $error("fill count above window length");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(pos_reg) < CW'(eff_n))
        else $error("write position outside window");

    a_sq_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_s_busy == sq_o_busy)
        else $error("squaring units out of step");

endmodule
